FILE: design/twt_pkg.sv
`timescale 1ns / 1ps
package twt_pkg;

  typedef enum logic [1:0] {
    KIND_CLOCK   = 2'd0,
    KIND_WAKE    = 2'd1,
    KIND_ADDED   = 2'd2,
    KIND_DROPPED = 2'd3
  } kind_e;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_ADD  = 1'b1
  } op_e;

  localparam logic [9:0] TpsReset = 10'd10;

  typedef struct packed {
    logic        valid;
    op_e         op;
    logic        done;
    logic [15:0] wake_event;
    logic [7:0]  owner;
    logic [15:0] delay;
  } probe_t;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [15:0] wake_event;
    logic [7:0]  owner;
  } report_t;

endpackage

FILE: design/twt_if.sv
`timescale 1ns / 1ps
interface twt_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [15:0] delay_seconds;
  logic [15:0] wake_event;
  logic [7:0]  owner_id;

  modport source (output valid, cmd, delay_seconds, wake_event, owner_id, input ready);
  modport sink (input valid, cmd, delay_seconds, wake_event, owner_id, output ready);
endinterface

interface twt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] event_out;
  logic [7:0]  owner_out;
  logic [2:0]  slot_index;
  logic [3:0]  hour_tens;
  logic [3:0]  hour_units;
  logic [2:0]  minute_tens;
  logic [3:0]  minute_units;
  logic [2:0]  second_tens;
  logic [3:0]  second_units;
  logic        last;

  modport source (output valid, kind, event_out, owner_out, slot_index, hour_tens,
                  hour_units, minute_tens, minute_units, second_tens, second_units,
                  last, input ready);
  modport sink (input valid, kind, event_out, owner_out, slot_index, hour_tens,
                hour_units, minute_tens, minute_units, second_tens, second_units,
                last, output ready);
endinterface

interface twt_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

FILE: design/timed_wakeup_table_with_clock.sv
`timescale 1ns / 1ps
// A plain tick (one not completing a second) puts its clock result in the output register;
// a result from cell n (added or wakeup) passes the start register, the probe registers of
// cells 0 to n-1 and the output register; a drop, or the clock result of any other tick,
// passes the start register, all cell probe registers and the output register. One item at a
// time: a walking item blocks input until past the last cell; an untaken output stalls all.
// Reset: all slots free, clock and tick count zero, ticks_per_second 10.
module timed_wakeup_table_with_clock #(
  parameter int SLOT_COUNT = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  twt_cfg_if.sink   cfg_i,
  twt_in_if.sink    in_i,
  twt_out_if.source out_o
);

  twt_pkg::probe_t  chain [SLOT_COUNT+1];
  twt_pkg::report_t rep [SLOT_COUNT];

  logic            en;
  logic            in_fire;
  logic            busy_q, busy_d;
  twt_pkg::probe_t start_q, start_d;
  logic [9:0]      tps_q;
  logic [9:0]      tps_eff;
  logic [9:0]      tick_q, tick_d;
  logic [10:0]     tick_next;
  logic            second;
  logic [3:0]      su_q, su_d, mu_q, mu_d, hu_q, hu_d, ht_q, ht_d;
  logic [2:0]      st_q, st_d, mt_q, mt_d;

  logic            any_rep;
  twt_pkg::report_t rep_sel;
  logic [2:0]      rep_idx;
  logic            final_hit;

  logic            ov_q, ov_d;
  twt_pkg::kind_e  kind_q, kind_d;
  logic [15:0]     evo_q, evo_d;
  logic [7:0]      owo_q, owo_d;
  logic [2:0]      idx_q, idx_d;
  logic            clk_dig_q, clk_dig_d;
  logic            last_q, last_d;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= twt_pkg::TpsReset;
    end else if (cfg_i.valid) begin
      tps_q <= cfg_i.data;
    end
  end

  assign en         = !ov_q || out_o.ready;
  assign in_i.ready = !busy_q && en;
  assign in_fire    = in_i.valid && in_i.ready;
  assign tps_eff    = (tps_q == 10'd0) ? 10'd1 : tps_q;
  assign tick_next  = {1'b0, tick_q} + 11'd1;
  assign second     = tick_next >= {1'b0, tps_eff};

  assign chain[0] = start_q;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    twt_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .probe_i  (chain[g]),
      .probe_o  (chain[g+1]),
      .report_o (rep[g])
    );
  end

  always_comb begin
    any_rep = 1'b0;
    rep_sel = '0;
    rep_idx = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (rep[i].valid) begin
        any_rep = 1'b1;
        rep_sel = rep_sel | rep[i];
        rep_idx = rep_idx | 3'(i);
      end
    end
  end

  assign final_hit = chain[SLOT_COUNT].valid;

  always_comb begin
    busy_d  = busy_q;
    start_d = start_q;
    tick_d  = tick_q;
    su_d    = su_q;
    st_d    = st_q;
    mu_d    = mu_q;
    mt_d    = mt_q;
    hu_d    = hu_q;
    ht_d    = ht_q;
    if (en) begin
      start_d.valid = 1'b0;
      if (final_hit) begin
        busy_d = 1'b0;
      end
    end
    if (in_fire) begin
      start_d.op         = twt_pkg::op_e'(in_i.cmd);
      start_d.done       = 1'b0;
      start_d.wake_event = in_i.wake_event;
      start_d.owner      = in_i.owner_id;
      start_d.delay      = in_i.delay_seconds;
      if (in_i.cmd == twt_pkg::OP_ADD) begin
        start_d.valid = 1'b1;
        busy_d        = 1'b1;
      end else if (second) begin
        start_d.valid = 1'b1;
        busy_d        = 1'b1;
        tick_d        = '0;
        if (su_q == 4'd9) begin
          su_d = '0;
          if (st_q == 3'd5) begin
            st_d = '0;
            if (mu_q == 4'd9) begin
              mu_d = '0;
              if (mt_q == 3'd5) begin
                mt_d = '0;
                if (hu_q == 4'd9) begin
                  hu_d = '0;
                  ht_d = (ht_q == 4'd9) ? 4'd0 : ht_q + 4'd1;
                end else begin
                  hu_d = hu_q + 4'd1;
                end
              end else begin
                mt_d = mt_q + 3'd1;
              end
            end else begin
              mu_d = mu_q + 4'd1;
            end
          end else begin
            st_d = st_q + 3'd1;
          end
        end else begin
          su_d = su_q + 4'd1;
        end
      end else begin
        tick_d = tick_next[9:0];
      end
    end
  end

  always_comb begin
    ov_d      = ov_q;
    kind_d    = kind_q;
    evo_d     = evo_q;
    owo_d     = owo_q;
    idx_d     = idx_q;
    clk_dig_d = clk_dig_q;
    last_d    = last_q;
    if (en) begin
      ov_d = 1'b0;
      if (any_rep) begin
        ov_d      = 1'b1;
        kind_d    = rep_sel.kind;
        evo_d     = rep_sel.wake_event;
        owo_d     = rep_sel.owner;
        idx_d     = rep_idx;
        clk_dig_d = 1'b0;
        last_d    = (rep_sel.kind == twt_pkg::KIND_ADDED);
      end else if (final_hit) begin
        if (chain[SLOT_COUNT].op == twt_pkg::OP_TICK) begin
          ov_d      = 1'b1;
          kind_d    = twt_pkg::KIND_CLOCK;
          evo_d     = '0;
          owo_d     = '0;
          idx_d     = '0;
          clk_dig_d = 1'b1;
          last_d    = 1'b1;
        end else if (!chain[SLOT_COUNT].done) begin
          ov_d      = 1'b1;
          kind_d    = twt_pkg::KIND_DROPPED;
          evo_d     = chain[SLOT_COUNT].wake_event;
          owo_d     = chain[SLOT_COUNT].owner;
          idx_d     = '0;
          clk_dig_d = 1'b0;
          last_d    = 1'b1;
        end
      end else if (in_fire && in_i.cmd == twt_pkg::OP_TICK && !second) begin
        ov_d      = 1'b1;
        kind_d    = twt_pkg::KIND_CLOCK;
        evo_d     = '0;
        owo_d     = '0;
        idx_d     = '0;
        clk_dig_d = 1'b1;
        last_d    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      start_q   <= '0;
      tick_q    <= '0;
      su_q      <= '0;
      st_q      <= '0;
      mu_q      <= '0;
      mt_q      <= '0;
      hu_q      <= '0;
      ht_q      <= '0;
      ov_q      <= 1'b0;
      kind_q    <= twt_pkg::KIND_CLOCK;
      evo_q     <= '0;
      owo_q     <= '0;
      idx_q     <= '0;
      clk_dig_q <= 1'b0;
      last_q    <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      start_q   <= start_d;
      tick_q    <= tick_d;
      su_q      <= su_d;
      st_q      <= st_d;
      mu_q      <= mu_d;
      mt_q      <= mt_d;
      hu_q      <= hu_d;
      ht_q      <= ht_d;
      ov_q      <= ov_d;
      kind_q    <= kind_d;
      evo_q     <= evo_d;
      owo_q     <= owo_d;
      idx_q     <= idx_d;
      clk_dig_q <= clk_dig_d;
      last_q    <= last_d;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.kind         = kind_q;
  assign out_o.event_out    = evo_q;
  assign out_o.owner_out    = owo_q;
  assign out_o.slot_index   = idx_q;
  assign out_o.hour_tens    = clk_dig_q ? ht_q : 4'd0;
  assign out_o.hour_units   = clk_dig_q ? hu_q : 4'd0;
  assign out_o.minute_tens  = clk_dig_q ? mt_q : 3'd0;
  assign out_o.minute_units = clk_dig_q ? mu_q : 4'd0;
  assign out_o.second_tens  = clk_dig_q ? st_q : 3'd0;
  assign out_o.second_units = clk_dig_q ? su_q : 4'd0;
  assign out_o.last         = last_q;

endmodule

FILE: design/twt_cell.sv
`timescale 1ns / 1ps
module twt_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  twt_pkg::probe_t  probe_i,
  output twt_pkg::probe_t  probe_o,
  output twt_pkg::report_t report_o
);

  logic [15:0]     ev_q, ev_d;
  logic [15:0]     rem_q, rem_d;
  logic [7:0]      own_q, own_d;
  twt_pkg::probe_t probe_q, probe_d;

  always_comb begin
    ev_d     = ev_q;
    rem_d    = rem_q;
    own_d    = own_q;
    probe_d  = probe_i;
    report_o = '0;
    if (probe_i.valid) begin
      case (probe_i.op)
        twt_pkg::OP_ADD: begin
          if (!probe_i.done && probe_i.wake_event != 16'd0 && ev_q == 16'd0) begin
            ev_d                = probe_i.wake_event;
            rem_d               = (probe_i.delay == 16'd0) ? 16'd1 : probe_i.delay;
            own_d               = probe_i.owner;
            probe_d.done        = 1'b1;
            report_o.valid      = 1'b1;
            report_o.kind       = twt_pkg::KIND_ADDED;
            report_o.wake_event = probe_i.wake_event;
            report_o.owner      = probe_i.owner;
          end
        end
        twt_pkg::OP_TICK: begin
          if (ev_q != 16'd0) begin
            rem_d = rem_q - 16'd1;
            if (rem_d == 16'd0) begin
              ev_d                = 16'd0;
              report_o.valid      = 1'b1;
              report_o.kind       = twt_pkg::KIND_WAKE;
              report_o.wake_event = ev_q;
              report_o.owner      = own_q;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q    <= '0;
      rem_q   <= '0;
      own_q   <= '0;
      probe_q <= '0;
    end else if (en_i) begin
      ev_q    <= ev_d;
      rem_q   <= rem_d;
      own_q   <= own_d;
      probe_q <= probe_d;
    end
  end

  assign probe_o = probe_q;

endmodule
